[sv/pcls_pkg.sv]
// Shared types and constants for the linear prime sieve counter.
// No dependencies; imported by every module of the block.
package pcls_pkg;

    // Fixed widths of the stream words.
    localparam int LIMIT_W       = 13;
    localparam int COUNT_W       = 10;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;

    // Default sizing of the sieve.
    localparam int DEF_MAX_LIMIT   = 4096;
    localparam int DEF_PRIME_SLOTS = 564;

    // Smallest number that is ever tested.
    localparam int FIRST_CANDIDATE = 2;

    // Control flags that travel with each number through the cell chain.
    typedef struct packed {
        logic valid;      // slot carries a number or the end marker
        logic eop;        // end marker of the current query
        logic composite;  // some cell found a prime factor
        logic taken;      // a cell already stored this number as a prime
    } tok_ctl_t;

endpackage

[sv/pcls_cell.sv]
// One sieve cell: holds one prime and its next multiple, tests passing numbers.
// Depends on pcls_pkg.
module pcls_cell #(
    parameter int VAL_W = 13
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  pcls_pkg::tok_ctl_t  in_ctl,
    input  logic [VAL_W-1:0]    in_val,
    output pcls_pkg::tok_ctl_t  out_ctl,
    output logic [VAL_W-1:0]    out_val
);
    import pcls_pkg::*;

    localparam int MULT_W = VAL_W + 1;

    logic              occ_reg;
    logic [VAL_W-1:0]  prime_reg;
    logic [MULT_W-1:0] mult_reg;
    tok_ctl_t          ctl_reg;
    logic [VAL_W-1:0]  val_reg;

    logic number_in;
    logic hit;
    logic capture;

    assign number_in = in_ctl.valid && !in_ctl.eop;
    assign hit       = number_in && occ_reg && (mult_reg == {1'b0, in_val});
    assign capture   = number_in && !occ_reg && !in_ctl.composite && !in_ctl.taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            ctl_reg <= '0;
        end else begin
            if (clear) begin
                occ_reg <= 1'b0;
            end else if (capture) begin
                occ_reg <= 1'b1;
            end
            ctl_reg.valid     <= in_ctl.valid;
            ctl_reg.eop       <= in_ctl.eop;
            ctl_reg.composite <= in_ctl.composite | hit;
            ctl_reg.taken     <= in_ctl.taken | capture;
        end
    end

    // The multiple walks up by the prime each time a number equal to it passes.
    always_ff @(posedge aclk) begin
        val_reg <= in_val;
        if (capture) begin
            prime_reg <= in_val;
            mult_reg  <= {in_val, 1'b0};
        end else if (hit) begin
            mult_reg  <= mult_reg + MULT_W'(prime_reg);
        end
    end

    assign out_ctl = ctl_reg;
    assign out_val = val_reg;

endmodule

[sv/pcls_ctrl.sv]
// Query sequencer: feeds numbers into the cell chain and counts primes at its tail.
// Depends on pcls_pkg.
module pcls_ctrl #(
    parameter int MAX_LIMIT   = pcls_pkg::DEF_MAX_LIMIT,
    parameter int PRIME_SLOTS = pcls_pkg::DEF_PRIME_SLOTS,
    parameter int VAL_W       = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pcls_pkg::LIMIT_W-1:0]  in_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pcls_pkg::COUNT_W-1:0]  out_count,
    output logic                          clear,
    output pcls_pkg::tok_ctl_t            feed_ctl,
    output logic [VAL_W-1:0]              feed_val,
    input  pcls_pkg::tok_ctl_t            tail_ctl
);
    import pcls_pkg::*;

    localparam int CNT_W = $clog2(PRIME_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [VAL_W-1:0]  lim_reg;
    logic [VAL_W-1:0]  num_reg;
    logic [CNT_W-1:0]  cnt_reg;
    tok_ctl_t          feed_ctl_reg;
    tok_ctl_t          feed_ctl_next;
    logic [VAL_W-1:0]  feed_val_reg;
    logic              out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic             accept;
    logic             load_result;
    logic [VAL_W-1:0] lim_clamped;
    logic             tail_prime;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign clear    = accept;

    // The finished count moves into the output register once the previous
    // word has gone or is leaving in this cycle.
    assign load_result = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Limits above the sieve size behave as the sieve size.
    assign lim_clamped = (32'(in_limit) > 32'(MAX_LIMIT)) ? VAL_W'(MAX_LIMIT)
                                                         : VAL_W'(in_limit);

    assign tail_prime = tail_ctl.valid && !tail_ctl.eop && !tail_ctl.composite;

    // While feeding, each cycle sends a number below the limit; the final slot,
    // after the last number, carries the end marker.
    always_comb begin
        feed_ctl_next = '0;
        if (state_reg == ST_FEED) begin
            feed_ctl_next.valid = 1'b1;
            feed_ctl_next.eop   = !(num_reg < lim_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            feed_ctl_reg  <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            feed_ctl_reg <= feed_ctl_next;
            if (load_result) begin
                out_valid_reg <= 1'b1;
                out_count_reg <= COUNT_W'(cnt_reg);
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            // Count stops at the number of cells, like a full prime list.
            if (accept) begin
                cnt_reg <= '0;
            end else if (tail_prime && (cnt_reg != CNT_W'(PRIME_SLOTS))) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        lim_reg   <= lim_clamped;
                        num_reg   <= VAL_W'(FIRST_CANDIDATE);
                        state_reg <= ST_FEED;
                    end
                end
                ST_FEED: begin
                    feed_val_reg <= num_reg;
                    if (num_reg < lim_reg) begin
                        num_reg <= num_reg + 1'b1;
                    end else begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (tail_ctl.valid && tail_ctl.eop) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_result) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign feed_ctl  = feed_ctl_reg;
    assign feed_val  = feed_val_reg;
    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

endmodule

[sv/prime_count_linear_sieve_unit.sv]
// Top level of the prime counter: sequencer plus a chain of sieve cells.
// Depends on pcls_pkg, pcls_ctrl and pcls_cell.
//
//   Channel  Direction  Word contents (lowest bit up)       Handshake
//   s_       input      limit[12:0], zero pad to 16 bits     s_tvalid/s_tready
//   m_       output     prime_count[9:0], zero pad to 16     m_tvalid/m_tready
//
// Candidate numbers enter the cell chain one per cycle, with limit clamped to
// MAX_LIMIT, and the end marker then crosses all PRIME_SLOTS cells before the
// result word turns valid. Reset is synchronous and active low; it empties the
// chain and the output register. The result word sits in an output register,
// so a stalled m_tready only holds the finished answer and a new limit is
// taken as soon as the sequencer is back in its idle state; if that next query
// finishes while the old word still waits, the sequencer holds in its done
// state and s_tready stays low.
module prime_count_linear_sieve_unit #(
    parameter int MAX_LIMIT   = pcls_pkg::DEF_MAX_LIMIT,
    parameter int PRIME_SLOTS = pcls_pkg::DEF_PRIME_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcls_pkg::S_TDATA_W-1:0]  s_tdata,   // limit[12:0], zeros above
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcls_pkg::M_TDATA_W-1:0]  m_tdata    // prime_count[9:0], zeros above
);
    import pcls_pkg::*;

    // Numbers up to MAX_LIMIT must fit, and the limit itself is compared.
    localparam int VAL_W = $clog2(MAX_LIMIT + 1);

    tok_ctl_t          chain_ctl [0:PRIME_SLOTS];
    logic [VAL_W-1:0]  chain_val [0:PRIME_SLOTS];
    logic              clear;
    logic [COUNT_W-1:0] count;

    pcls_ctrl #(
        .MAX_LIMIT   (MAX_LIMIT),
        .PRIME_SLOTS (PRIME_SLOTS),
        .VAL_W       (VAL_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_limit  (s_tdata[LIMIT_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (count),
        .clear     (clear),
        .feed_ctl  (chain_ctl[0]),
        .feed_val  (chain_val[0]),
        .tail_ctl  (chain_ctl[PRIME_SLOTS])
    );

    // Each cell takes the first prime that reaches it unclaimed and from then
    // on flags every multiple of that prime as it streams past.
    for (genvar g = 0; g < PRIME_SLOTS; g++) begin : g_cell
        pcls_cell #(
            .VAL_W (VAL_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (clear),
            .in_ctl  (chain_ctl[g]),
            .in_val  (chain_val[g]),
            .out_ctl (chain_ctl[g+1]),
            .out_val (chain_val[g+1])
        );
    end

    assign m_tdata = M_TDATA_W'(count);

endmodule

[sv/pcls_checker.sv]
// Port-level checks for the prime counter, bound to the top level.
// Depends on pcls_pkg and prime_count_linear_sieve_unit.
module pcls_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pcls_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pcls_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pcls_pkg::*;

    // A query blocks further words until it has finished.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a query is in progress");

    // A new answer only appears when the sequencer was busy the cycle before.
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a running query");

    // The count never exceeds its ten bits.
    a_count_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:COUNT_W] == '0))
        else $error("result word has bits set above the count");

    // A stalled result word holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

endmodule

bind prime_count_linear_sieve_unit pcls_checker u_pcls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
